FILE: hdl/bti_pkg.sv
package bti_pkg;

    localparam int ITERATIONS_DEF = 16;
    localparam int XW             = 32;
    localparam int TW             = 17;
    localparam int MAX_TIME_W     = 31;
    localparam int EPS_W          = 16;
    localparam int TOL_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 31;

    localparam logic [TW-1:0] T_ONE = 17'd65536;
    localparam logic [TW-1:0] T_ZERO = 17'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_EPSILON   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOLERANCE = 2'd2;

    localparam logic [MAX_TIME_W-1:0] MAX_TIME_RST        = 31'd0;
    localparam logic [EPS_W-1:0]      START_EPSILON_RST   = 16'd1;
    localparam logic [TOL_W-1:0]      MATCH_TOLERANCE_RST = 16'd16;

    typedef struct packed {
        logic                 done;
        logic signed [XW-1:0] x0;
        logic signed [XW-1:0] x1;
        logic signed [XW-1:0] x2;
        logic signed [XW-1:0] x3;
        logic signed [XW-1:0] q;
        logic [TW-1:0]        u;
        logic [TW-1:0]        v;
    } bti_item_t;

    function automatic logic signed [XW-1:0] mid_x(input logic signed [XW-1:0] a,
                                                   input logic signed [XW-1:0] b);
        logic signed [XW:0] s;
        s = {a[XW-1], a} + {b[XW-1], b};
        return s[XW:1];
    endfunction

    function automatic logic [TW-1:0] mid_t(input logic [TW-1:0] a,
                                            input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW:1];
    endfunction

endpackage

FILE: hdl/bti_entry.sv
module bti_entry
    import bti_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  accept,
    input  logic signed [XW-1:0]  start_x,
    input  logic signed [XW-1:0]  out_anchor_x,
    input  logic signed [XW-1:0]  in_anchor_x,
    input  logic signed [XW-1:0]  end_x,
    input  logic signed [XW-1:0]  query_x,
    input  logic [MAX_TIME_W-1:0] max_time,
    input  logic [EPS_W-1:0]      start_epsilon,
    output logic                  out_valid,
    output bti_item_t             out_item
);

    logic                   valid0_reg;
    logic signed [XW-1:0]   x0_reg;
    logic signed [XW-1:0]   x1_reg;
    logic signed [XW-1:0]   x2_reg;
    logic signed [XW-1:0]   x3_reg;
    logic [MAX_TIME_W-1:0]  q_reg;
    logic [MAX_TIME_W-1:0]  q_next;
    logic                   valid1_reg;
    bti_item_t              item_reg;
    bti_item_t              item_next;
    logic signed [XW:0]     q_ext;
    logic signed [XW:0]     d_start;
    logic signed [XW:0]     d_end;
    logic signed [XW:0]     eps_ext;

    // clamp query to [0, max_time]
    always_comb
    begin
        if (query_x[XW-1])
        begin
            q_next = '0;
        end
        else if (query_x[MAX_TIME_W-1:0] > max_time)
        begin
            q_next = max_time;
        end
        else
        begin
            q_next = query_x[MAX_TIME_W-1:0];
        end
    end

    always_comb
    begin
        q_ext   = {2'b00, q_reg};
        eps_ext = {{(XW+1-EPS_W){1'b0}}, start_epsilon};
        d_start = q_ext - {x0_reg[XW-1], x0_reg};
        d_end   = {x3_reg[XW-1], x3_reg} - q_ext;

        item_next.done = 1'b0;
        item_next.x0   = x0_reg;
        item_next.x1   = x1_reg;
        item_next.x2   = x2_reg;
        item_next.x3   = x3_reg;
        item_next.q    = q_ext[XW-1:0];
        item_next.u    = T_ZERO;
        item_next.v    = T_ONE;
        if (d_start < eps_ext)
        begin
            item_next.done = 1'b1;
            item_next.v    = T_ZERO;
        end
        else if (d_end < eps_ext)
        begin
            item_next.done = 1'b1;
            item_next.u    = T_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid0_reg <= accept;
            valid1_reg <= valid0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && accept)
        begin
            x0_reg <= start_x;
            x1_reg <= out_anchor_x;
            x2_reg <= in_anchor_x;
            x3_reg <= end_x;
            q_reg  <= q_next;
        end
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid1_reg;
    assign out_item  = item_reg;

endmodule

FILE: hdl/bti_cell.sv
module bti_cell
    import bti_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [TOL_W-1:0] match_tolerance,
    input  logic             in_valid,
    input  bti_item_t        in_item,
    output logic             out_valid,
    output bti_item_t        out_item
);

    logic                 valid_reg;
    bti_item_t            item_reg;
    bti_item_t            item_next;
    logic signed [XW-1:0] a;
    logic signed [XW-1:0] b;
    logic signed [XW-1:0] c;
    logic signed [XW-1:0] d;
    logic signed [XW-1:0] e;
    logic signed [XW-1:0] f;
    logic signed [XW:0]   diff;
    logic [XW:0]          abs_diff;

    // one de Casteljau midpoint split per cell
    always_comb
    begin
        a        = mid_x(in_item.x0, in_item.x1);
        b        = mid_x(in_item.x1, in_item.x2);
        c        = mid_x(in_item.x2, in_item.x3);
        d        = mid_x(a, b);
        e        = mid_x(b, c);
        f        = mid_x(d, e);
        diff     = {f[XW-1], f} - {in_item.q[XW-1], in_item.q};
        abs_diff = diff[XW] ? (XW+1)'(0) - diff : diff;

        item_next = in_item;
        if (!in_item.done)
        begin
            if (abs_diff < {{(XW+1-TOL_W){1'b0}}, match_tolerance})
            begin
                item_next.done = 1'b1;
            end
            else if (diff[XW])
            begin
                item_next.x0 = f;
                item_next.x1 = e;
                item_next.x2 = c;
                item_next.u  = mid_t(in_item.u, in_item.v);
            end
            else
            begin
                item_next.x1 = a;
                item_next.x2 = d;
                item_next.x3 = f;
                item_next.v  = mid_t(in_item.u, in_item.v);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: hdl/bezier_time_inversion.sv
// channel   | dir | fields (low bit first)
// s_axis    | in  | start_x, out_anchor_x, in_anchor_x, end_x, query_x (32 b each)
// m_axis    | out | curve_t (17 b, padded to 24)
// cfg       | in  | cfg_index selects max_time, start_epsilon, match_tolerance
//
// A request passes through two entry stages (clamp, end margins), one cell per
// bisection round and one output register before m_axis_tvalid rises. One
// request is in the cell chain at a time; the next is accepted the cycle after
// the previous result reaches the output register.
// Reset clears all valid flags and loads register defaults.
// A stalled output freezes the chain once the next result reaches the last cell.
module bezier_time_inversion
    import bti_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [5*XW-1:0]       s_axis_tdata,  // start_x, out_anchor_x, in_anchor_x, end_x, query_x
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,  // curve_t, zero pad
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MAX_TIME_W-1:0] max_time_reg;
    logic [EPS_W-1:0]      start_epsilon_reg;
    logic [TOL_W-1:0]      match_tolerance_reg;

    logic                  inflight_reg;
    logic                  out_valid_reg;
    logic [TW-1:0]         out_t_reg;
    logic                  accept;
    logic                  adv;
    logic                  last_valid;
    bti_item_t             last_item;

    logic                  valid_chain [ITERATIONS+1];
    bti_item_t             item_chain  [ITERATIONS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_time_reg        <= MAX_TIME_RST;
            start_epsilon_reg   <= START_EPSILON_RST;
            match_tolerance_reg <= MATCH_TOLERANCE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MAX_TIME:        max_time_reg        <= cfg_data[MAX_TIME_W-1:0];
                CFG_START_EPSILON:   start_epsilon_reg   <= cfg_data[EPS_W-1:0];
                CFG_MATCH_TOLERANCE: match_tolerance_reg <= cfg_data[TOL_W-1:0];
                default:             ;
            endcase
        end
    end

    assign s_axis_tready = !inflight_reg;
    assign accept        = s_axis_tvalid && !inflight_reg;
    assign last_valid    = valid_chain[ITERATIONS];
    assign last_item     = item_chain[ITERATIONS];
    assign adv           = !(last_valid && out_valid_reg && !m_axis_tready);

    bti_entry u_entry (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .accept        (accept),
        .start_x       (s_axis_tdata[XW-1:0]),
        .out_anchor_x  (s_axis_tdata[2*XW-1:XW]),
        .in_anchor_x   (s_axis_tdata[3*XW-1:2*XW]),
        .end_x         (s_axis_tdata[4*XW-1:3*XW]),
        .query_x       (s_axis_tdata[5*XW-1:4*XW]),
        .max_time      (max_time_reg),
        .start_epsilon (start_epsilon_reg),
        .out_valid     (valid_chain[0]),
        .out_item      (item_chain[0])
    );

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        bti_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .adv             (adv),
            .match_tolerance (match_tolerance_reg),
            .in_valid        (valid_chain[i]),
            .in_item         (item_chain[i]),
            .out_valid       (valid_chain[i+1]),
            .out_item        (item_chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                inflight_reg <= 1'b1;
            end
            else if (last_valid && adv)
            begin
                inflight_reg <= 1'b0;
            end

            if (last_valid && adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_valid && adv)
        begin
            out_t_reg <= mid_t(last_item.u, last_item.v);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(24-TW){1'b0}}, out_t_reg};

endmodule

FILE: hdl/bti_checker.sv
module bti_checker
    import bti_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TW-1:0] <= T_ONE))
        else $error("curve_t above one");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:TW] == '0))
        else $error("tdata pad bits set");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while one in flight");

    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared right after acceptance");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind bezier_time_inversion bti_checker u_bti_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/bezier_time_inversion_tb.sv
module bezier_time_inversion_tb;
    import bti_pkg::*;

    localparam int     LATENCY     = ITERATIONS_DEF + 3;
    localparam int     PHASE_REQS  = 150;
    localparam int     HOLD_CYCLES = 400;
    localparam longint X_MAX       = 64'sh0000_0000_7FFF_FFFF;
    localparam longint X_MIN       = -X_MAX - 1;
    localparam longint T_FULL      = 65536;

    typedef struct packed {
        logic signed [XW-1:0] qx;
        logic signed [XW-1:0] ex;
        logic signed [XW-1:0] ix;
        logic signed [XW-1:0] ox;
        logic signed [XW-1:0] sx;
    } curve_req_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        curve_req_t            req;
        bit                    has_t;
        logic [TW-1:0]         t;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [5*XW-1:0]       s_axis_tdata;  // start_x, out_anchor_x, in_anchor_x, end_x, query_x
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;  // curve_t, zero pad
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [MAX_TIME_W-1:0] max_time_r;
    logic [EPS_W-1:0]      eps_r;
    logic [TOL_W-1:0]      tol_r;

    logic [TW-1:0] curve_t_due[$];
    int            src_idle_pct   = 0;
    int            sink_stall_pct = 0;
    bit            squeeze        = 1'b0;
    int            reqs_sent      = 0;
    int            results_seen   = 0;
    int            mismatches     = 0;

    bezier_time_inversion u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("bezier_time_inversion_tb NOT OK");
        $finish;
    end

    function automatic logic signed [XW-1:0] clip_x(input longint v);
        if (v > X_MAX)
            return X_MAX[XW-1:0];
        if (v < X_MIN)
            return X_MIN[XW-1:0];
        return v[XW-1:0];
    endfunction

    function automatic logic [TW-1:0] invert_time(input curve_req_t r);
        longint p0, p1, p2, p3, q, a, b, c, d, e, f, abs_diff, lo, hi, t;
        longint mt, eps, tol;
        mt  = max_time_r;
        eps = eps_r;
        tol = tol_r;
        p0  = longint'(r.sx);
        p1  = longint'(r.ox);
        p2  = longint'(r.ix);
        p3  = longint'(r.ex);
        q   = longint'(r.qx);
        if (q < 0)
            q = 0;
        if (q > mt)
            q = mt;
        if (q - p0 < eps)
            return T_ZERO;
        if (p3 - q < eps)
            return T_ONE;
        lo = 0;
        hi = T_FULL;
        for (int i = 0; i < ITERATIONS_DEF; i++)
        begin
            a = (p0 + p1) >>> 1;
            b = (p1 + p2) >>> 1;
            c = (p2 + p3) >>> 1;
            d = (a + b) >>> 1;
            e = (b + c) >>> 1;
            f = (d + e) >>> 1;
            abs_diff = (f < q) ? q - f : f - q;
            if (abs_diff < tol)
                break;
            if (f < q)
            begin
                p0 = f;
                p1 = e;
                p2 = c;
                lo = (lo + hi) >>> 1;
            end
            else
            begin
                p1 = a;
                p2 = d;
                p3 = f;
                hi = (lo + hi) >>> 1;
            end
        end
        t = (lo + hi) >>> 1;
        if (t < 0)
            t = 0;
        if (t > T_FULL)
            t = T_FULL;
        return t[TW-1:0];
    endfunction

    // mostly ordered curves around an in-range query, some at the margins,
    // some with the query out of range, the rest plain noise
    function automatic curve_req_t make_req();
        curve_req_t r;
        longint     q, lo_gap, hi_gap, span, spread, mt, eps;
        int         pick;
        mt   = max_time_r;
        eps  = eps_r;
        pick = $urandom_range(99);
        r.sx = $urandom;
        r.ox = $urandom;
        r.ix = $urandom;
        r.ex = $urandom;
        r.qx = $urandom;
        if (pick < 15)
            return r;
        span = longint'(1) << (4 + $urandom_range(26));
        q    = longint'($urandom) % (mt + 1);
        if ($urandom_range(1))
            q = q % (span + 1);
        r.qx = clip_x(q);
        if (pick >= 30 && pick < 40)
        begin
            if ($urandom_range(1))
            begin
                q    = 0;
                r.qx = clip_x(-1 - longint'($urandom_range(32'h3FFF_FFFF)));
            end
            else
            begin
                q    = mt;
                r.qx = clip_x(mt + 1 + longint'($urandom_range(32'h3FFF_FFFF)));
            end
        end
        lo_gap = eps + longint'($urandom_range(span));
        hi_gap = eps + longint'($urandom_range(span));
        if (pick < 30)
        begin
            if ($urandom_range(1))
                lo_gap = eps + longint'($urandom_range(2)) - 1;
            else
                hi_gap = eps + longint'($urandom_range(2)) - 1;
        end
        r.sx   = clip_x(q - lo_gap);
        r.ex   = clip_x(q + hi_gap);
        spread = lo_gap + hi_gap;
        if ($urandom_range(9) != 0)
        begin
            r.ox = clip_x(q - lo_gap + longint'($urandom_range(spread)));
            r.ix = clip_x(q + hi_gap - longint'($urandom_range(spread)));
        end
        return r;
    endfunction

    function automatic plan_row_t req_row(input logic [XW-1:0] sx, ox, ix, ex, qx,
                                          input bit has_t = 1'b0,
                                          input logic [TW-1:0] t = '0);
        plan_row_t row;
        row.kind  = ROW_REQ;
        row.req   = {qx, ex, ix, ox, sx};
        row.has_t = has_t;
        row.t     = t;
        row.idx   = CFG_MAX_TIME;
        row.val   = '0;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row       = req_row('0, '0, '0, '0, '0);
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.val   = val;
        return row;
    endfunction

    task automatic offer(input curve_req_t r, input bit has_t, input logic [TW-1:0] t);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = r;
        do
            @(posedge clk);
        while (!s_axis_tready);
        curve_t_due = {curve_t_due, (has_t ? t : invert_time(r))};
        reqs_sent++;
    endtask

    // drop valid and wait for the block to empty
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (curve_t_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_MAX_TIME:        max_time_r = val;
            CFG_START_EPSILON:   eps_r      = val[EPS_W-1:0];
            CFG_MATCH_TOLERANCE: tol_r      = val[TOL_W-1:0];
            default:             ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] mt, eps, tol);
        settle();
        write_reg(CFG_MAX_TIME, mt);
        write_reg(CFG_START_EPSILON, eps);
        write_reg(CFG_MATCH_TOLERANCE, tol);
    endtask

    initial
    begin : sink_proc
        int hold_left;
        bit held;
        hold_left     = 0;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
                m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin : check_proc
        logic [TW-1:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (curve_t_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected curve_t %0d", m_axis_tdata[TW-1:0]);
                end
                else
                begin
                    want = curve_t_due.pop_front();
                    if (m_axis_tdata[TW-1:0] !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("curve_t mismatch on result %0d: expected %0d, got %0d",
                                     results_seen, want, m_axis_tdata[TW-1:0]);
                    end
                end
            end
        end
    end

    initial
    begin : stim_proc
        plan_row_t plan[$];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_MAX_TIME;
        cfg_data      = '0;
        max_time_r    = MAX_TIME_RST;
        eps_r         = START_EPSILON_RST;
        tol_r         = MATCH_TOLERANCE_RST;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: query clamps to zero
        plan = {plan, req_row(32'h0, 32'h40000, 32'h80000, 32'hC0000, 32'h12345, 1'b1, T_ZERO)};
        plan = {plan, req_row(32'hFF9C_0000, 32'hFFC0_0000, 32'hFFE0_0000, 32'h0, 32'h5,
                              1'b1, T_ONE)};
        plan = {plan, cfg_row(CFG_MAX_TIME, 31'h7FFF_FFFF)};
        plan = {plan, req_row(32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h8000_0000)};
        plan = {plan, req_row(32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              1'b1, T_ONE)};
        plan = {plan, req_row(32'h10000, 32'h20000, 32'h28000, 32'h300000, 32'h10000,
                              1'b1, T_ZERO)};
        plan = {plan, req_row(32'h10000, 32'h20000, 32'h28000, 32'h300000, 32'h10001)};
        plan = {plan, req_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h0)};
        plan = {plan, req_row(32'h0, 32'h100000, 32'h200000, 32'h300000, 32'h180000,
                              1'b1, 17'd32768)};
        plan = {plan, req_row(32'h0, 32'h100000, 32'h200000, 32'h300000, 32'h2FFFFF)};
        plan = {plan, req_row(32'h0, 32'h500000, 32'hFFD0_0000, 32'h200000, 32'h100000)};
        plan = {plan, req_row(32'h300000, 32'h200000, 32'h100000, 32'h0, 32'h180000,
                              1'b1, T_ZERO)};
        plan = {plan, req_row(32'h0, 32'h280000, 32'h80000, 32'h300000, 32'h40000)};
        plan = {plan, cfg_row(CFG_START_EPSILON, 31'd0)};
        plan = {plan, req_row(32'h10000, 32'h20000, 32'h28000, 32'h300000, 32'h10000)};
        plan = {plan, req_row(32'h10000, 32'h20000, 32'h28000, 32'h300000, 32'h8000,
                              1'b1, T_ZERO)};
        plan = {plan, req_row(32'h0, 32'h100000, 32'h200000, 32'h300000, 32'h300000)};
        plan = {plan, cfg_row(CFG_START_EPSILON, 31'hFFFF)};
        plan = {plan, req_row(32'h0, 32'h100000, 32'h200000, 32'h300000, 32'hFFFE,
                              1'b1, T_ZERO)};
        plan = {plan, req_row(32'h0, 32'h100000, 32'h200000, 32'h300000, 32'h2F0001)};
        plan = {plan, req_row(32'h0, 32'h100000, 32'h200000, 32'h300000, 32'h2F0002,
                              1'b1, T_ONE)};
        plan = {plan, cfg_row(CFG_MATCH_TOLERANCE, 31'd0)};
        plan = {plan, req_row(32'h0, 32'h100000, 32'h200000, 32'h300000, 32'h180001)};
        plan = {plan, cfg_row(CFG_MATCH_TOLERANCE, 31'hFFFF)};
        plan = {plan, req_row(32'h0, 32'h100000, 32'h200000, 32'h300000, 32'h188000,
                              1'b1, 17'd32768)};
        plan = {plan, cfg_row(CFG_MAX_TIME, 31'h10000)};
        plan = {plan, req_row(32'h0, 32'h8000, 32'h10000, 32'h300000, 32'h7FFF_FFFF)};

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                offer(plan[i].req, plan[i].has_t, plan[i].t);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_config(31'h7FFF_FFFF, 31'd1, 31'd16);
                1: set_config(31'($urandom), 31'd0, 31'd0);
                2: set_config(31'h7FFF_FFFF, 31'hFFFF, 31'hFFFF);
                3: set_config(31'd0, 31'($urandom_range(16'hFFFF)),
                              31'($urandom_range(16'hFFFF)));
                default: set_config(31'($urandom), 31'($urandom_range(16'hFFFF)),
                                    31'($urandom_range(16'hFFFF)));
            endcase
            src_idle_pct   = (ph == 1) ? 76 : (ph == 3) ? 31 : 0;
            sink_stall_pct = (ph == 2) ? 76 : (ph == 3) ? 31 : 0;
            squeeze        = (ph == 4);
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                // hold the sender until the block has drained
                if (ph == 4 && n == PHASE_REQS / 2)
                begin
                    @(negedge clk);
                    s_axis_tvalid = 1'b0;
                    while (curve_t_due.size() != 0)
                        @(posedge clk);
                end
                offer(make_req(), 1'b0, '0);
            end
        end

        settle();
        $display("%0d requests sent, %0d curve_t results checked, %0d mismatches",
                 reqs_sent, results_seen, mismatches);
        $display("covered clamps, end margins, bisection, config extremes, stalls and back-pressure");
        if (mismatches == 0)
            $display("bezier_time_inversion_tb OK");
        else
            $display("bezier_time_inversion_tb NOT OK");
        $finish;
    end

endmodule
